FILE: rtl/iwc_pkg.sv
// ----------------------------------------------------------------------------
// iwc_pkg
// Shared types and constants of the irrigation watering controller.
// ----------------------------------------------------------------------------
package iwc_pkg;

  localparam int unsigned PauseTicks     = 60000;
  localparam int unsigned TicksPerSecond = 1000;
  localparam int unsigned PumpCntW       = 18;
  localparam int unsigned PauseCntW      = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 12;
  localparam logic [3:0]  CycleMax       = 4'hF;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_STANDBY  = 3'd1,
    MODE_WATERING = 3'd2,
    MODE_CHECKING = 3'd3,
    MODE_WAITING  = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_POWER_LEVEL  = 3'd1,
    CFG_WIN_START    = 3'd2,
    CFG_WIN_END      = 3'd3,
    CFG_MAX_CYCLES   = 3'd4,
    CFG_PUMP_SECONDS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] threshold;
    logic [7:0]  power_level;
    logic [4:0]  win_start;
    logic [4:0]  win_end;
    logic [3:0]  max_cycles;
    logic [7:0]  pump_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] moisture;
    logic [4:0]  hour;
    logic [4:0]  day;
  } item_t;

  typedef struct packed {
    logic                 switched_on;
    mode_e                mode;
    logic                 done;
    logic [3:0]           cycle_count;
    logic [4:0]           last_day;
    logic                 pump_run;
    logic [PumpCntW-1:0]  pump_cnt;
    logic                 pause_run;
    logic [PauseCntW-1:0] pause_cnt;
    logic [7:0]           power;
    logic                 stage_en;
  } state_t;

endpackage

FILE: rtl/irrigation_watering_controller.sv
// ----------------------------------------------------------------------------
// irrigation_watering_controller
// Pump controller for one plant: ticks, switch on and switch off events.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i/in_ready_o with kind, moisture, hour and day;
//   kind 0 is a 1 ms tick, 1 switches on, 2 switches off
//   output channel: out_valid_o/out_ready_i with drive level, output enable,
//   mode, cycles today and run done, one transaction per input transaction
//   config: write cfg_data_i to register cfg_idx_i while cfg_we_i is high,
//   only while the block is idle
//   result path: input register, then the state/result register
//   throughput: one transaction per cycle unless a result is held, set by the
//   combinational state update between the input and state/result registers
//   reset: controller state cleared, mode off, config registers to defaults
//   stall: a held result freezes the state; if the input register is empty,
//   it takes one more, then in_ready_o drops until the result leaves
// ----------------------------------------------------------------------------
module irrigation_watering_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [11:0]                   moisture_i,
  input  logic [4:0]                    hour_i,
  input  logic [4:0]                    day_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    drive_level_o,
  output logic                          output_enabled_o,
  output logic [2:0]                    mode_o,
  output logic [3:0]                    cycles_today_o,
  output logic                          run_done_o,
  input  logic                          cfg_we_i,
  input  logic [iwc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iwc_pkg::CfgDataW-1:0]  cfg_data_i
);

  iwc_pkg::cfg_t   cfg;
  iwc_pkg::state_t state;
  iwc_pkg::item_t  item_q;
  logic            s1_vld_q, s1_vld_d;
  logic            out_vld_q, out_vld_d;
  logic            advance, fire, in_acc;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = s1_vld_q && advance;
  assign in_ready_o = !s1_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc)    s1_vld_d = 1'b1;
    else if (fire) s1_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (fire)             out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.kind     <= kind_i;
      item_q.moisture <= moisture_i;
      item_q.hour     <= hour_i;
      item_q.day      <= day_i;
    end
  end

  iwc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  iwc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_o (state)
  );

  assign out_valid_o      = out_vld_q;
  assign drive_level_o    = state.power;
  assign output_enabled_o = state.stage_en;
  assign mode_o           = state.mode;
  assign cycles_today_o   = state.cycle_count;
  assign run_done_o       = state.done;

endmodule

FILE: rtl/iwc_cfg.sv
// ----------------------------------------------------------------------------
// iwc_cfg
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module iwc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iwc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iwc_pkg::CfgDataW-1:0]  cfg_data_i,
  output iwc_pkg::cfg_t                 cfg_o
);

  iwc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iwc_pkg::CFG_THRESHOLD:    cfg_d.threshold    = cfg_data_i[11:0];
        iwc_pkg::CFG_POWER_LEVEL:  cfg_d.power_level  = cfg_data_i[7:0];
        iwc_pkg::CFG_WIN_START:    cfg_d.win_start    = cfg_data_i[4:0];
        iwc_pkg::CFG_WIN_END:      cfg_d.win_end      = cfg_data_i[4:0];
        iwc_pkg::CFG_MAX_CYCLES:   cfg_d.max_cycles   = cfg_data_i[3:0];
        iwc_pkg::CFG_PUMP_SECONDS: cfg_d.pump_seconds = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= 12'd0;
      cfg_q.power_level  <= 8'd0;
      cfg_q.win_start    <= 5'd6;
      cfg_q.win_end      <= 5'd23;
      cfg_q.max_cycles   <= 4'd3;
      cfg_q.pump_seconds <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/iwc_core.sv
// ----------------------------------------------------------------------------
// iwc_core
// Controller state and single-pass update for one transaction.
// ----------------------------------------------------------------------------
module iwc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  iwc_pkg::item_t item_i,
  input  iwc_pkg::cfg_t  cfg_i,
  output iwc_pkg::state_t state_o
);

  iwc_pkg::state_t st_q, st_d, tk;
  logic                          in_win;
  logic [iwc_pkg::PumpCntW-1:0]  pump_load;

  assign pump_load = iwc_pkg::PumpCntW'(cfg_i.pump_seconds)
                   * iwc_pkg::PumpCntW'(iwc_pkg::TicksPerSecond);

  // tick path
  always_comb begin
    tk = st_q;
    if (tk.pump_run && tk.pump_cnt != '0) tk.pump_cnt = tk.pump_cnt - 1'b1;
    if (tk.pause_run && tk.pause_cnt != '0) tk.pause_cnt = tk.pause_cnt - 1'b1;
    if (tk.last_day != item_i.day) begin
      tk.cycle_count = 4'd0;
      tk.last_day    = item_i.day;
      tk.done        = 1'b0;
    end
    in_win = (item_i.hour >= cfg_i.win_start) && (item_i.hour < cfg_i.win_end);
    if (!tk.switched_on)                                 tk.mode = iwc_pkg::MODE_OFF;
    else if (item_i.moisture >= cfg_i.threshold)         tk.mode = iwc_pkg::MODE_STANDBY;
    else if (in_win && !tk.done)                         tk.mode = iwc_pkg::MODE_WATERING;
    else if (in_win && tk.cycle_count < cfg_i.max_cycles) tk.mode = iwc_pkg::MODE_CHECKING;
    else                                                 tk.mode = iwc_pkg::MODE_WAITING;

    case (tk.mode)
      iwc_pkg::MODE_STANDBY: begin
        tk.pump_run  = 1'b0;
        tk.pump_cnt  = '0;
        tk.pause_run = 1'b0;
        tk.pause_cnt = '0;
        tk.power     = 8'd0;
      end
      iwc_pkg::MODE_WATERING: begin
        if (!tk.pump_run) begin
          tk.pump_cnt = pump_load;
          tk.pump_run = 1'b1;
          tk.power    = cfg_i.power_level;
        end
        if (tk.pump_cnt == '0) begin
          if (tk.cycle_count != iwc_pkg::CycleMax) tk.cycle_count = tk.cycle_count + 1'b1;
          tk.last_day = item_i.day;
          tk.power    = 8'd0;
          tk.pump_run = 1'b0;
          tk.done     = 1'b1;
        end
      end
      iwc_pkg::MODE_CHECKING: begin
        if (!tk.pause_run) begin
          tk.pause_cnt = iwc_pkg::PauseCntW'(iwc_pkg::PauseTicks);
          tk.pause_run = 1'b1;
          tk.power     = 8'd0;
        end
        if (tk.pause_cnt == '0) begin
          tk.power     = 8'd0;
          tk.pause_run = 1'b0;
          tk.done      = 1'b0;
        end
      end
      default: tk.power = 8'd0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    if (fire_i) begin
      case (item_i.kind)
        iwc_pkg::KIND_TICK: st_d = tk;
        iwc_pkg::KIND_ON: begin
          st_d.switched_on = 1'b1;
          st_d.stage_en    = 1'b1;
        end
        iwc_pkg::KIND_OFF: begin
          st_d.switched_on = 1'b0;
          st_d.done        = 1'b0;
          st_d.cycle_count = 4'd0;
          st_d.stage_en    = 1'b0;
          st_d.pump_run    = 1'b0;
          st_d.pump_cnt    = '0;
          st_d.pause_run   = 1'b0;
          st_d.pause_cnt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

  // drive only while watering
  a_power_watering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.power != 8'd0 |-> st_q.mode == iwc_pkg::MODE_WATERING)
    else $error("pump power without watering");

  a_pump_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pump_run |-> st_q.pump_cnt == '0)
    else $error("stopped pump timer holds a count");

  a_pause_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pause_run |-> st_q.pause_cnt == '0)
    else $error("stopped pause timer holds a count");

  a_stage_tracks_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.stage_en == st_q.switched_on)
    else $error("output stage and on flag disagree");

  a_hold_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(st_q))
    else $error("state changed without a transaction");

endmodule

FILE: tb/sv/irrigation_watering_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_watering_controller_test
// Self-checking testbench for the irrigation watering controller. A directed
// table and random phases drive ticks and switch events through the input
// handshake. A behavioral model of the pump logic predicts every status
// transaction the directed table leaves open, and a monitor compares each one
// field by field. Sender gaps vary by phase, receiver stalls over time.
// ----------------------------------------------------------------------------
module irrigation_watering_controller_test;

  localparam logic [1:0]  KindSpare = 2'd3;
  localparam int unsigned PrintCap  = 40;

  typedef struct packed {
    logic [7:0] drive;
    logic       enabled;
    logic [2:0] mode;
    logic [3:0] cycles;
    logic       done;
  } status_t;

  typedef struct {
    logic                         is_cfg;
    iwc_pkg::cfg_idx_e            idx;
    logic [iwc_pkg::CfgDataW-1:0] data;
    iwc_pkg::item_t               it;
    logic                         typed;
    status_t                      want;
  } row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [1:0]                   kind_i;
  logic [11:0]                  moisture_i;
  logic [4:0]                   hour_i;
  logic [4:0]                   day_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [7:0]                   drive_level_o;
  logic                         output_enabled_o;
  logic [2:0]                   mode_o;
  logic [3:0]                   cycles_today_o;
  logic                         run_done_o;
  logic                         cfg_we_i;
  logic [iwc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [iwc_pkg::CfgDataW-1:0] cfg_data_i;

  irrigation_watering_controller u_top (.*);

  // pump model state
  iwc_pkg::cfg_t                 setting;
  logic                          plant_on;
  iwc_pkg::mode_e                plant_mode;
  logic                          plant_done;
  logic [3:0]                    plant_cycles;
  logic [4:0]                    plant_day;
  logic                          plant_pump_run;
  logic [iwc_pkg::PumpCntW-1:0]  plant_pump_cnt;
  logic                          plant_pause_run;
  logic [iwc_pkg::PauseCntW-1:0] plant_pause_cnt;
  logic [7:0]                    plant_power;
  logic                          plant_stage;

  status_t     status_due[$];
  status_t     status_head;
  row_t        directed[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 1;
  int unsigned gap_max = 0;
  int unsigned hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void stop_plant_timers();
    plant_pump_run  = 1'b0;
    plant_pump_cnt  = '0;
    plant_pause_run = 1'b0;
    plant_pause_cnt = '0;
  endfunction

  function automatic status_t plant_status_after(iwc_pkg::item_t it);
    logic in_window;
    case (it.kind)
      iwc_pkg::KIND_TICK: begin
        if (plant_pump_run && plant_pump_cnt != 0) plant_pump_cnt = plant_pump_cnt - 1'b1;
        if (plant_pause_run && plant_pause_cnt != 0) plant_pause_cnt = plant_pause_cnt - 1'b1;
        if (plant_day != it.day) begin
          plant_cycles = '0;
          plant_day    = it.day;
          plant_done   = 1'b0;
        end
        in_window = (it.hour >= setting.win_start) && (it.hour < setting.win_end);
        if (!plant_on) plant_mode = iwc_pkg::MODE_OFF;
        else if (it.moisture >= setting.threshold) plant_mode = iwc_pkg::MODE_STANDBY;
        else if (in_window && !plant_done) plant_mode = iwc_pkg::MODE_WATERING;
        else if (in_window && plant_cycles < setting.max_cycles)
          plant_mode = iwc_pkg::MODE_CHECKING;
        else plant_mode = iwc_pkg::MODE_WAITING;
        case (plant_mode)
          iwc_pkg::MODE_STANDBY: begin
            stop_plant_timers();
            plant_power = '0;
          end
          iwc_pkg::MODE_WATERING: begin
            if (!plant_pump_run) begin
              plant_pump_cnt = iwc_pkg::PumpCntW'(setting.pump_seconds
                                                  * iwc_pkg::TicksPerSecond);
              plant_pump_run = 1'b1;
              plant_power    = setting.power_level;
            end
            if (plant_pump_cnt == 0) begin
              if (plant_cycles != iwc_pkg::CycleMax) plant_cycles = plant_cycles + 1'b1;
              plant_day      = it.day;
              plant_power    = '0;
              plant_pump_run = 1'b0;
              plant_done     = 1'b1;
            end
          end
          iwc_pkg::MODE_CHECKING: begin
            if (!plant_pause_run) begin
              plant_pause_cnt = iwc_pkg::PauseCntW'(iwc_pkg::PauseTicks);
              plant_pause_run = 1'b1;
              plant_power     = '0;
            end
            if (plant_pause_cnt == 0) begin
              plant_power     = '0;
              plant_pause_run = 1'b0;
              plant_done      = 1'b0;
            end
          end
          default: plant_power = '0;
        endcase
      end
      iwc_pkg::KIND_ON: begin
        plant_on    = 1'b1;
        plant_stage = 1'b1;
      end
      iwc_pkg::KIND_OFF: begin
        plant_on     = 1'b0;
        plant_done   = 1'b0;
        plant_cycles = '0;
        plant_stage  = 1'b0;
        stop_plant_timers();
      end
      default: ;
    endcase
    return '{drive: plant_power, enabled: plant_stage, mode: plant_mode,
             cycles: plant_cycles, done: plant_done};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PrintCap) begin
      $display("mismatch: %s on transaction %0d, got %0h, expected %0h",
               what, results_seen, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (status_due.size() == 0) begin
        report_mismatch("transaction with nothing expected", 32'(mode_o), 32'(0));
      end else begin
        status_head = status_due.pop_front();
        if (drive_level_o !== status_head.drive)
          report_mismatch("drive_level", 32'(drive_level_o), 32'(status_head.drive));
        if (output_enabled_o !== status_head.enabled)
          report_mismatch("output_enabled", 32'(output_enabled_o), 32'(status_head.enabled));
        if (mode_o !== status_head.mode)
          report_mismatch("mode", 32'(mode_o), 32'(status_head.mode));
        if (cycles_today_o !== status_head.cycles)
          report_mismatch("cycles_today", 32'(cycles_today_o), 32'(status_head.cycles));
        if (run_done_o !== status_head.done)
          report_mismatch("run_done", 32'(run_done_o), 32'(status_head.done));
      end
      results_seen++;
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned rx_style;
    int unsigned rx_cycle;
    hold_left = 0;
    rx_style  = 0;
    rx_cycle  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      rx_cycle++;
      if (rx_cycle % 89 == 0) rx_style = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (rx_cycle % 7 >= 2);
        endcase
      end
    end
  end

  task automatic offer(iwc_pkg::item_t it, logic typed, status_t want);
    status_t due;
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i     <= it.kind;
    moisture_i <= it.moisture;
    hour_i     <= it.hour;
    day_i      <= it.day;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    due = plant_status_after(it);
    status_due.push_back(typed ? want : due);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(iwc_pkg::cfg_idx_e idx, logic [iwc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      iwc_pkg::CFG_THRESHOLD:    setting.threshold    = data;
      iwc_pkg::CFG_POWER_LEVEL:  setting.power_level  = data[7:0];
      iwc_pkg::CFG_WIN_START:    setting.win_start    = data[4:0];
      iwc_pkg::CFG_WIN_END:      setting.win_end      = data[4:0];
      iwc_pkg::CFG_MAX_CYCLES:   setting.max_cycles   = data[3:0];
      iwc_pkg::CFG_PUMP_SECONDS: setting.pump_seconds = data[7:0];
      default: ;
    endcase
  endtask

  function automatic row_t cfg_row(iwc_pkg::cfg_idx_e idx, int unsigned data);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = iwc_pkg::CfgDataW'(data);
    r.it     = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t item_row(logic [1:0] kind, int unsigned moisture,
                                    int unsigned hour, int unsigned day);
    row_t r;
    r.is_cfg      = 1'b0;
    r.idx         = iwc_pkg::CFG_THRESHOLD;
    r.data        = '0;
    r.it.kind     = kind;
    r.it.moisture = 12'(moisture);
    r.it.hour     = 5'(hour);
    r.it.day      = 5'(day);
    r.typed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  function automatic row_t with_status(row_t r, int unsigned drive, int unsigned enabled,
                                       iwc_pkg::mode_e mode, int unsigned cycles,
                                       int unsigned done);
    r.typed        = 1'b1;
    r.want.drive   = 8'(drive);
    r.want.enabled = 1'(enabled);
    r.want.mode    = mode;
    r.want.cycles  = 4'(cycles);
    r.want.done    = 1'(done);
    return r;
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic random_phase(int unsigned n, int unsigned gaps, int unsigned hold);
    iwc_pkg::item_t it;
    int unsigned r;
    logic [4:0] day_now;
    wait_idle();
    r = $urandom_range(0, 3);
    cfg_write(iwc_pkg::CFG_THRESHOLD,
              12'((r == 0) ? pick(0, 4095) : $urandom_range(1024, 4095)));
    cfg_write(iwc_pkg::CFG_POWER_LEVEL, 12'(pick(0, 255)));
    r = $urandom_range(0, 3);
    cfg_write(iwc_pkg::CFG_WIN_START, 12'((r == 0) ? pick(0, 23) : $urandom_range(0, 8)));
    r = $urandom_range(0, 3);
    cfg_write(iwc_pkg::CFG_WIN_END, 12'((r == 0) ? pick(0, 24) : $urandom_range(16, 24)));
    cfg_write(iwc_pkg::CFG_MAX_CYCLES, 12'(pick(0, 15)));
    r = $urandom_range(0, 9);
    cfg_write(iwc_pkg::CFG_PUMP_SECONDS, 12'((r < 6) ? 0 : (r < 8) ? 1 : pick(0, 255)));
    gap_max = gaps;
    day_now = 5'($urandom_range(0, 31));
    for (int i = 0; i < int'(n); i++) begin
      r           = $urandom_range(0, 99);
      it.moisture = 12'($urandom_range(0, 4095));
      it.hour     = 5'($urandom_range(0, 31));
      it.day      = 5'($urandom_range(0, 31));
      if (i == 0 || r < 5) begin
        it.kind = iwc_pkg::KIND_ON;
      end else if (r < 9) begin
        it.kind = iwc_pkg::KIND_OFF;
      end else if (r < 12) begin
        it.kind = KindSpare;
      end else begin
        it.kind = iwc_pkg::KIND_TICK;
        if ($urandom_range(0, 19) == 0) day_now = 5'($urandom_range(0, 31));
        it.day = day_now;
        if ($urandom_range(0, 3) != 0 && setting.threshold != 0)
          it.moisture = 12'($urandom_range(0, setting.threshold - 1));
        if ($urandom_range(0, 4) != 0 && setting.win_start < setting.win_end)
          it.hour = 5'($urandom_range(setting.win_start, setting.win_end - 1));
      end
      if (i == int'(n / 2)) hold_request = hold;
      offer(it, 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = iwc_pkg::KIND_TICK;
    moisture_i  = '0;
    hour_i      = '0;
    day_i       = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = iwc_pkg::CFG_THRESHOLD;
    cfg_data_i  = '0;

    setting = '{threshold: 12'd0, power_level: 8'd0, win_start: 5'd6, win_end: 5'd23,
                max_cycles: 4'd3, pump_seconds: 8'd0};
    plant_on     = 1'b0;
    plant_mode   = iwc_pkg::MODE_OFF;
    plant_done   = 1'b0;
    plant_cycles = '0;
    plant_day    = '0;
    plant_power  = '0;
    plant_stage  = 1'b0;
    stop_plant_timers();

    // reset defaults: everything off, threshold zero
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 4095, 31, 31),
                                   0, 0, iwc_pkg::MODE_OFF, 0, 0));
    directed.push_back(with_status(item_row(KindSpare, 0, 0, 0),
                                   0, 0, iwc_pkg::MODE_OFF, 0, 0));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_ON, 0, 0, 0),
                                   0, 1, iwc_pkg::MODE_OFF, 0, 0));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 0, 0),
                                   0, 1, iwc_pkg::MODE_STANDBY, 0, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_THRESHOLD, 4095));
    directed.push_back(cfg_row(iwc_pkg::CFG_POWER_LEVEL, 255));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_START, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_END, 24));
    directed.push_back(cfg_row(iwc_pkg::CFG_MAX_CYCLES, 15));
    // zero-length watering finishes at once
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 0, 0),
                                   0, 1, iwc_pkg::MODE_WATERING, 1, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 4094, 23, 0),
                                   0, 1, iwc_pkg::MODE_CHECKING, 1, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 24, 0),
                                   0, 1, iwc_pkg::MODE_WAITING, 1, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 31, 0),
                                   0, 1, iwc_pkg::MODE_WAITING, 1, 1));
    directed.push_back(item_row(iwc_pkg::KIND_TICK, 2047, 12, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_OFF, 0, 0, 0),
                                   0, 0, iwc_pkg::MODE_WATERING, 0, 0));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 100, 12, 1),
                                   0, 0, iwc_pkg::MODE_OFF, 0, 0));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_ON, 0, 0, 0),
                                   0, 1, iwc_pkg::MODE_OFF, 0, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_PUMP_SECONDS, 255));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 12, 1),
                                   255, 1, iwc_pkg::MODE_WATERING, 0, 0));
    directed.push_back(item_row(iwc_pkg::KIND_TICK, 1365, 12, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 4095, 12, 1),
                                   0, 1, iwc_pkg::MODE_STANDBY, 0, 0));
    // empty windows
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_START, 23));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_END, 23));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 23, 1),
                                   0, 1, iwc_pkg::MODE_WAITING, 0, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_START, 20));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_END, 3));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 0, 1),
                                   0, 1, iwc_pkg::MODE_WAITING, 0, 0));
    // no cycles allowed: watering still runs once, then only waiting
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_START, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_WIN_END, 24));
    directed.push_back(cfg_row(iwc_pkg::CFG_MAX_CYCLES, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_PUMP_SECONDS, 0));
    directed.push_back(cfg_row(iwc_pkg::CFG_POWER_LEVEL, 170));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 2730, 5, 2),
                                   0, 1, iwc_pkg::MODE_WATERING, 1, 1));
    directed.push_back(with_status(item_row(iwc_pkg::KIND_TICK, 0, 5, 2),
                                   0, 1, iwc_pkg::MODE_WAITING, 1, 1));
    directed.push_back(item_row(iwc_pkg::KIND_TICK, 4094, 10, 2));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_max = 3;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        cfg_write(directed[i].idx, directed[i].data);
      end else begin
        offer(directed[i].it, directed[i].typed, directed[i].want);
      end
    end

    for (int p = 0; p < 10; p++) begin
      random_phase(70, (p % 3 == 0) ? 0 : $urandom_range(2, 8), (p == 3) ? 60 : 0);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/iwc_pkg.sv
rtl/iwc_cfg.sv
rtl/iwc_core.sv
rtl/irrigation_watering_controller.sv
tb/sv/irrigation_watering_controller_test.sv
